FILE: rtl/msh_pkg.sv
package msh_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_TABLE_LEN   = 24;

  localparam int PRESCALE_BITS = 14;
  localparam int VEC_W         = 33;
  localparam int ANG_W         = 25;
  localparam int ATAN_W        = 21;
  localparam int ROUND_SHIFT   = 8;

  localparam int STATUS_READY_BIT = 0;
  localparam int STATUS_OVF_BIT   = 3;

  localparam logic signed [ANG_W-1:0] ANGLE_180  = 25'sd4608000;
  localparam logic signed [ANG_W-1:0] ANGLE_360  = 25'sd9216000;
  localparam logic signed [ANG_W-1:0] ROUND_HALF = 25'sd128;
  localparam logic [15:0]             HEADING_WRAP = 16'd36000;

  // atan(2^-i) in units of 1/256 centidegree, rounded to nearest.
  localparam logic [ATAN_W-1:0] ATAN_STEP [ATAN_TABLE_LEN] = '{
    21'd1152000, 21'd680065, 21'd359328, 21'd182400,
    21'd91554,   21'd45822,  21'd22916,  21'd11459,
    21'd5730,    21'd2865,   21'd1432,   21'd716,
    21'd358,     21'd179,    21'd90,     21'd45,
    21'd22,      21'd11,     21'd6,      21'd3,
    21'd1,       21'd1,      21'd0,      21'd0
  };

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  typedef struct packed {
    logic               data_ready;
    logic               overflow;
    logic signed [15:0] x_count;
    logic signed [15:0] y_count;
    logic signed [15:0] z_count;
    logic signed [19:0] x_centi_tesla;
    logic signed [19:0] y_centi_tesla;
    logic signed [19:0] z_centi_tesla;
    logic               heading_valid;
  } side_t;

endpackage

FILE: rtl/msh_if.sv
interface msh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_one;
  logic [7:0] x_low_byte;
  logic [7:0] x_high_byte;
  logic [7:0] y_low_byte;
  logic [7:0] y_high_byte;
  logic [7:0] z_low_byte;
  logic [7:0] z_high_byte;
  logic [7:0] status_two;

  modport source (
    output valid, status_one, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
           z_low_byte, z_high_byte, status_two,
    input  ready
  );
  modport sink (
    input  valid, status_one, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
           z_low_byte, z_high_byte, status_two,
    output ready
  );
endinterface

interface msh_out_if;
  logic               valid;
  logic               ready;
  logic               data_ready;
  logic               overflow;
  logic signed [15:0] x_count;
  logic signed [15:0] y_count;
  logic signed [15:0] z_count;
  logic signed [19:0] x_centi_tesla;
  logic signed [19:0] y_centi_tesla;
  logic signed [19:0] z_centi_tesla;
  logic               heading_valid;
  logic [15:0]        heading_centideg;

  modport source (
    output valid, data_ready, overflow, x_count, y_count, z_count, x_centi_tesla,
           y_centi_tesla, z_centi_tesla, heading_valid, heading_centideg,
    input  ready
  );
  modport sink (
    input  valid, data_ready, overflow, x_count, y_count, z_count, x_centi_tesla,
           y_centi_tesla, z_centi_tesla, heading_valid, heading_centideg,
    output ready
  );
endinterface

FILE: rtl/magnetometer_sample_heading_top.sv
// Decodes one raw magnetometer read per transaction into ready and overflow flags, signed
// X/Y/Z counts, the counts in 0.01 uT, and a compass heading in hundredths of a degree
// from a CORDIC atan2. The pipeline takes a new transaction every cycle unless a stalled
// output has filled every stage, and has CORDIC_STEPS + 2 register stages (capped at 24
// iterations): one input decode stage, one stage per CORDIC iteration, and one stage for
// the wrap and rounding.
// A stalled output holds its result; stages behind it keep filling empty slots, and the
// input is refused only once every stage holds a transaction.
module magnetometer_sample_heading_top #(
  parameter int CORDIC_STEPS = msh_pkg::CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  msh_in_if.sink    sample,
  msh_out_if.source result
);

  localparam int STEPS = (CORDIC_STEPS > msh_pkg::ATAN_TABLE_LEN) ?
                         msh_pkg::ATAN_TABLE_LEN : CORDIC_STEPS;
  localparam int LAST  = STEPS + 1;

  logic [LAST:0]        vld;
  logic [LAST:0]        load;
  msh_pkg::side_t       side_q [0:LAST];
  msh_pkg::vec_t        x_q [0:STEPS];
  msh_pkg::vec_t        y_q [0:STEPS];
  msh_pkg::ang_t        z_q [0:STEPS];
  logic [15:0]          heading_q;

  logic signed [15:0]   xc, yc, zc;
  msh_pkg::vec_t        xs, ys;
  msh_pkg::side_t       side_in;
  msh_pkg::ang_t        z_wrap;
  msh_pkg::ang_t        z_round;
  logic [15:0]          heading_next;

  always_comb begin
    load[LAST] = !vld[LAST] || result.ready;
    for (int s = LAST - 1; s >= 0; s--) begin
      load[s] = !vld[s] || load[s+1];
    end
  end

  assign sample.ready = load[0];

  always_comb begin
    xc = signed'({sample.x_high_byte, sample.x_low_byte});
    yc = signed'({sample.y_high_byte, sample.y_low_byte});
    zc = signed'({sample.z_high_byte, sample.z_low_byte});
    xs = signed'({{(msh_pkg::VEC_W - 16 - msh_pkg::PRESCALE_BITS){xc[15]}}, xc,
                  {msh_pkg::PRESCALE_BITS{1'b0}}});
    ys = signed'({{(msh_pkg::VEC_W - 16 - msh_pkg::PRESCALE_BITS){yc[15]}}, yc,
                  {msh_pkg::PRESCALE_BITS{1'b0}}});
    side_in = '0;
    if (sample.status_one[msh_pkg::STATUS_READY_BIT]) begin
      side_in.data_ready    = 1'b1;
      side_in.overflow      = sample.status_two[msh_pkg::STATUS_OVF_BIT];
      side_in.x_count       = xc;
      side_in.y_count       = yc;
      side_in.z_count       = zc;
      side_in.x_centi_tesla = (signed'({{4{xc[15]}}, xc}) <<< 4) - signed'({{4{xc[15]}}, xc});
      side_in.y_centi_tesla = (signed'({{4{yc[15]}}, yc}) <<< 4) - signed'({{4{yc[15]}}, yc});
      side_in.z_centi_tesla = (signed'({{4{zc[15]}}, zc}) <<< 4) - signed'({{4{zc[15]}}, zc});
      side_in.heading_valid = (xc != 16'sd0) || (yc != 16'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) begin
        vld[0] <= sample.valid;
      end
      for (int s = 1; s <= LAST; s++) begin
        if (load[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      side_q[0] <= side_in;
      if (xc[15]) begin
        x_q[0] <= -xs;
        y_q[0] <= -ys;
        z_q[0] <= msh_pkg::ANGLE_180;
      end else begin
        x_q[0] <= xs;
        y_q[0] <= ys;
        z_q[0] <= '0;
      end
    end
    for (int s = 1; s <= LAST; s++) begin
      if (load[s]) begin
        side_q[s] <= side_q[s-1];
      end
    end
    // One CORDIC micro-rotation per stage, vectoring Y toward zero.
    for (int k = 0; k < STEPS; k++) begin
      if (load[k+1]) begin
        if (!y_q[k][msh_pkg::VEC_W-1]) begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + signed'({{(msh_pkg::ANG_W - msh_pkg::ATAN_W){1'b0}},
                                        msh_pkg::ATAN_STEP[k]});
        end else begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - signed'({{(msh_pkg::ANG_W - msh_pkg::ATAN_W){1'b0}},
                                        msh_pkg::ATAN_STEP[k]});
        end
      end
    end
  end

  always_comb begin
    z_wrap = z_q[STEPS][msh_pkg::ANG_W-1] ? z_q[STEPS] + msh_pkg::ANGLE_360 : z_q[STEPS];
    z_round = z_wrap + msh_pkg::ROUND_HALF;
    heading_next = z_round[msh_pkg::ROUND_SHIFT +: 16];
    if (heading_next == msh_pkg::HEADING_WRAP || !side_q[STEPS].heading_valid) begin
      heading_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (load[LAST]) begin
      heading_q <= heading_next;
    end
  end

  assign result.valid            = vld[LAST];
  assign result.data_ready       = side_q[LAST].data_ready;
  assign result.overflow         = side_q[LAST].overflow;
  assign result.x_count          = side_q[LAST].x_count;
  assign result.y_count          = side_q[LAST].y_count;
  assign result.z_count          = side_q[LAST].z_count;
  assign result.x_centi_tesla    = side_q[LAST].x_centi_tesla;
  assign result.y_centi_tesla    = side_q[LAST].y_centi_tesla;
  assign result.z_centi_tesla    = side_q[LAST].z_centi_tesla;
  assign result.heading_valid    = side_q[LAST].heading_valid;
  assign result.heading_centideg = heading_q;

`ifndef SYNTHESIS
  a_not_ready_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.data_ready |->
      !result.overflow && result.x_count == 16'sd0 && result.y_count == 16'sd0 &&
      result.z_count == 16'sd0 && !result.heading_valid && result.heading_centideg == 16'd0)
    else $error("Result without data ready carries nonzero fields.");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.heading_centideg < msh_pkg::HEADING_WRAP)
    else $error("Heading out of range.");

  a_invalid_heading_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.heading_valid |-> result.heading_centideg == 16'd0)
    else $error("Invalid heading is not zero.");

  a_heading_valid_xy: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data_ready |->
      result.heading_valid == (result.x_count != 16'sd0 || result.y_count != 16'sd0))
    else $error("Heading valid flag disagrees with the counts.");

  a_centi_scale: assert property (@(posedge clk) disable iff (rst)
    result.valid |->
      result.x_centi_tesla == 20'(signed'({{4{result.x_count[15]}}, result.x_count}) * 20'sd15))
    else $error("X field scaling disagrees with the count.");
`endif

endmodule
